FILE: src/pmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pmb_pkg;

    // Default geometry
    localparam int TILE_SIZE_DEF  = 64;
    localparam int MAX_LEVELS_DEF = 7;

    // Field widths
    localparam int HEIGHT_W    = 16;
    localparam int SPAN_W      = 8;
    localparam int LEVEL_W     = 3;
    localparam int COORD_OUT_W = 6;

    // Largest level count the 3-bit register can express
    localparam int LEVEL_LIMIT = 7;

    localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RST = 3'd7;

    // Height summary of one pyramid entry
    typedef struct packed {
        logic [HEIGHT_W-1:0] low;
        logic [HEIGHT_W-1:0] high;
        logic                sat;
    } t_heights;

    // Width of an internal coordinate; at least two bits so the parent column slices cleanly
    function automatic int f_coord_w(input int block);
        f_coord_w = ($clog2(block) < 2) ? 2 : $clog2(block);
    endfunction

endpackage

`default_nettype wire

FILE: src/pmb_raster.sv
`timescale 1ns / 1ps
`default_nettype none

module pmb_raster #(
    parameter int TILE_SIZE = pmb_pkg::TILE_SIZE_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_take,
    input  wire logic [pmb_pkg::HEIGHT_W-1:0]       i_base_min,
    input  wire logic [pmb_pkg::SPAN_W-1:0]         i_span,
    output logic [pmb_pkg::f_coord_w(TILE_SIZE)-1:0] o_x,
    output logic [pmb_pkg::f_coord_w(TILE_SIZE)-1:0] o_y,
    output pmb_pkg::t_heights                       o_heights
);

    localparam int CW = pmb_pkg::f_coord_w(TILE_SIZE);
    localparam int HW = pmb_pkg::HEIGHT_W;
    localparam logic [CW-1:0] LAST_COORD = CW'(TILE_SIZE - 1);

    logic [CW-1:0] r_x, n_x;
    logic [CW-1:0] r_y, n_y;
    logic [HW:0]   sum;

    // Advance the raster position, wrapping at the end of a row and of the block
    always_comb begin
        n_x = r_x;
        n_y = r_y;
        if (i_take) begin
            if (r_x == LAST_COORD) begin
                n_x = '0;
                n_y = (r_y == LAST_COORD) ? '0 : r_y + 1'b1;
            end else begin
                n_x = r_x + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
            r_y <= '0;
        end else begin
            r_x <= n_x;
            r_y <= n_y;
        end
    end

    // Form the base cell maximum, clamped on overflow
    assign sum = {1'b0, i_base_min} + (HW + 1)'(i_span);

    always_comb begin
        o_heights.low  = i_base_min;
        o_heights.high = sum[HW] ? '1 : sum[HW-1:0];
        o_heights.sat  = sum[HW];
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

`default_nettype wire

FILE: src/pmb_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module pmb_walker #(
    parameter int TILE_SIZE  = pmb_pkg::TILE_SIZE_DEF,
    parameter int MAX_LEVELS = pmb_pkg::MAX_LEVELS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [pmb_pkg::LEVEL_W-1:0]          i_level_count,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [pmb_pkg::f_coord_w(TILE_SIZE)-1:0] i_in_x,
    input  wire logic [pmb_pkg::f_coord_w(TILE_SIZE)-1:0] i_in_y,
    input  wire pmb_pkg::t_heights                    i_in_heights,
    input  wire logic                                 i_out_ready,
    output logic                                      o_e_valid,
    output logic [pmb_pkg::LEVEL_W-1:0]               o_e_level,
    output logic [pmb_pkg::f_coord_w(TILE_SIZE)-1:0]  o_e_x,
    output logic [pmb_pkg::f_coord_w(TILE_SIZE)-1:0]  o_e_y,
    output pmb_pkg::t_heights                         o_e_heights,
    output logic                                      o_e_last
);

    localparam int CW       = pmb_pkg::f_coord_w(TILE_SIZE);
    localparam int PXW      = CW - 1;
    localparam int LW       = pmb_pkg::LEVEL_W;
    localparam int HALF     = (TILE_SIZE / 2 > 0) ? TILE_SIZE / 2 : 1;
    localparam int LV_CAP   = (MAX_LEVELS > pmb_pkg::LEVEL_LIMIT) ? pmb_pkg::LEVEL_LIMIT
                                                                 : MAX_LEVELS;
    localparam int GL       = LV_CAP - 1;
    localparam int MEM_DEPTH = ((GL < 1) ? 1 : GL) << PXW;
    localparam int ADDR_W   = (MEM_DEPTH < 2) ? 1 : $clog2(MEM_DEPTH);

    localparam logic [PXW:0]  HALF_C   = (PXW + 1)'(HALF);
    localparam logic [LW-1:0] LV_CAP_C = LW'(LV_CAP);
    localparam logic [LW-1:0] LV_ONE   = LW'(1);

    // Group memory address: group level above the entry, then parent column
    function automatic logic [ADDR_W-1:0] f_addr(input logic [LW-1:0] lvl,
                                                 input logic [PXW-1:0] px);
        if (int'(lvl) < GL) begin
            f_addr = ADDR_W'({lvl, px});
        end else begin
            f_addr = '0;
        end
    endfunction

    // Partial 2x2 groups, one entry per group level and parent column
    pmb_pkg::t_heights mem [0:MEM_DEPTH-1];

    logic                r_e_valid, n_e_valid;
    logic [LW-1:0]       r_e_level, n_e_level;
    logic [CW-1:0]       r_e_x, n_e_x;
    logic [CW-1:0]       r_e_y, n_e_y;
    pmb_pkg::t_heights   r_e_h, n_e_h;

    pmb_pkg::t_heights   r_rdata;
    logic                r_fwd_valid;
    logic [ADDR_W-1:0]   r_fwd_addr;
    pmb_pkg::t_heights   r_fwd_data;

    logic [LW-1:0]       eff_levels;
    logic [LW-1:0]       top_level;
    logic [PXW-1:0]      px;
    logic [ADDR_W-1:0]   cur_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                child_first;
    logic                upd;
    logic                casc;
    logic                e_go;
    logic                in_take;
    pmb_pkg::t_heights   grp;
    pmb_pkg::t_heights   merged;

    // Clamp the configured level count
    always_comb begin
        if (i_level_count == '0) begin
            eff_levels = LV_ONE;
        end else if (i_level_count > LV_CAP_C) begin
            eff_levels = LV_CAP_C;
        end else begin
            eff_levels = i_level_count;
        end
        top_level = eff_levels - LV_ONE;
    end

    // Decide group update and cascade from the entry's coordinates
    always_comb begin
        px          = r_e_x[CW-1:1];
        cur_addr    = f_addr(r_e_level, px);
        child_first = !r_e_x[0] && !r_e_y[0];
        upd         = ({1'b0, px} < HALF_C) && (r_e_level < top_level);
        casc        = upd && r_e_x[0] && r_e_y[0];
        e_go        = r_e_valid && i_out_ready;
        o_in_ready  = !r_e_valid || (e_go && !casc);
        in_take     = i_in_valid && o_in_ready;
    end

    // Merge the entry into its group, forwarding last cycle's write
    always_comb begin
        grp = (r_fwd_valid && (r_fwd_addr == cur_addr)) ? r_fwd_data : r_rdata;
        if (child_first) begin
            merged = r_e_h;
        end else begin
            merged.low  = (r_e_h.low < grp.low) ? r_e_h.low : grp.low;
            merged.high = (r_e_h.high > grp.high) ? r_e_h.high : grp.high;
            merged.sat  = r_e_h.sat | grp.sat;
        end
    end

    // Next entry: parent on cascade, otherwise a new record or empty
    always_comb begin
        n_e_valid = r_e_valid;
        n_e_level = r_e_level;
        n_e_x     = r_e_x;
        n_e_y     = r_e_y;
        n_e_h     = r_e_h;
        if (e_go && casc) begin
            n_e_level = r_e_level + LV_ONE;
            n_e_x     = {1'b0, r_e_x[CW-1:1]};
            n_e_y     = {1'b0, r_e_y[CW-1:1]};
            n_e_h     = merged;
        end else if (in_take) begin
            n_e_valid = 1'b1;
            n_e_level = '0;
            n_e_x     = i_in_x;
            n_e_y     = i_in_y;
            n_e_h     = i_in_heights;
        end else if (e_go) begin
            n_e_valid = 1'b0;
        end
        rd_addr = f_addr(n_e_level, n_e_x[CW-1:1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_e_valid   <= n_e_valid;
            r_fwd_valid <= e_go && upd;
        end
    end

    // Hold the entry payload and the forwarding copy
    always_ff @(posedge i_clk) begin
        r_e_level  <= n_e_level;
        r_e_x      <= n_e_x;
        r_e_y      <= n_e_y;
        r_e_h      <= n_e_h;
        r_fwd_addr <= cur_addr;
        r_fwd_data <= merged;
    end

    // Group memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (e_go && upd) begin
            mem[cur_addr] <= merged;
        end
        r_rdata <= mem[rd_addr];
    end

    assign o_e_valid   = r_e_valid;
    assign o_e_level   = r_e_level;
    assign o_e_x       = r_e_x;
    assign o_e_y       = r_e_y;
    assign o_e_heights = r_e_h;
    assign o_e_last    = !casc;

endmodule

`default_nettype wire

FILE: src/pmb_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module pmb_out_stage #(
    parameter int TILE_SIZE = pmb_pkg::TILE_SIZE_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_e_valid,
    output logic                                      o_e_ready,
    input  wire logic [pmb_pkg::LEVEL_W-1:0]          i_e_level,
    input  wire logic [pmb_pkg::f_coord_w(TILE_SIZE)-1:0] i_e_x,
    input  wire logic [pmb_pkg::f_coord_w(TILE_SIZE)-1:0] i_e_y,
    input  wire pmb_pkg::t_heights                    i_e_heights,
    input  wire logic                                 i_e_last,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [pmb_pkg::LEVEL_W-1:0]               o_level,
    output logic [pmb_pkg::COORD_OUT_W-1:0]           o_cell_x,
    output logic [pmb_pkg::COORD_OUT_W-1:0]           o_cell_y,
    output logic [pmb_pkg::HEIGHT_W-1:0]              o_low_height,
    output logic [pmb_pkg::HEIGHT_W-1:0]              o_high_height,
    output logic                                      o_saturated,
    output logic                                      o_last
);

    localparam int OW = pmb_pkg::COORD_OUT_W;

    logic                           r_valid;
    logic                           load;
    logic [pmb_pkg::LEVEL_W-1:0]    r_level;
    logic [OW-1:0]                  r_x;
    logic [OW-1:0]                  r_y;
    pmb_pkg::t_heights              r_h;
    logic                           r_last;

    // Load when empty or when the held transaction leaves this cycle
    assign o_e_ready = !r_valid || i_ready;
    assign load      = i_e_valid && o_e_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_e_ready) begin
            r_valid <= i_e_valid;
        end
    end

    // Capture the result, coordinates masked to the output width
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_level <= i_e_level;
            r_x     <= OW'(i_e_x);
            r_y     <= OW'(i_e_y);
            r_h     <= i_e_heights;
            r_last  <= i_e_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_level       = r_level;
    assign o_cell_x      = r_x;
    assign o_cell_y      = r_y;
    assign o_low_height  = r_h.low;
    assign o_high_height = r_h.high;
    assign o_saturated   = r_h.sat;
    assign o_last        = r_last;

endmodule

`default_nettype wire

FILE: src/minmax_pyramid_builder.sv
// Min/max pyramid builder. Height records of a TILE_SIZE x TILE_SIZE block
// arrive in raster order; each gives one base entry, and a record at odd
// column and odd row also gives the parent entries it completes, up to the
// configured level count (min of the minima, max of the maxima, OR of the
// saturation flags). One entry register walks up the levels doing one
// read-modify-write of the partial-group RAM per cycle while the output is
// not stalled, and a new record is not taken while a parent entry is still
// to be formed. The base entry of a record passes through the entry
// register and then the output register, and its parents follow one per
// cycle while the output is not stalled.
// The partial-group RAM holds (levels - 1) x 2^(clog2(TILE_SIZE) - 1)
// entries and is not cleared after reset; every group is written by its
// first child before it is read. Write the level count only while idle.
`timescale 1ns / 1ps
`default_nettype none

module minmax_pyramid_builder #(
    parameter int TILE_SIZE  = pmb_pkg::TILE_SIZE_DEF,
    parameter int MAX_LEVELS = pmb_pkg::MAX_LEVELS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pmb_pkg::LEVEL_W-1:0]     i_cfg_level_count,
    // records in
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [pmb_pkg::HEIGHT_W-1:0]    i_base_min,
    input  wire logic [pmb_pkg::SPAN_W-1:0]      i_span,
    // entries out
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [pmb_pkg::LEVEL_W-1:0]          o_level,
    output logic [pmb_pkg::COORD_OUT_W-1:0]      o_cell_x,
    output logic [pmb_pkg::COORD_OUT_W-1:0]      o_cell_y,
    output logic [pmb_pkg::HEIGHT_W-1:0]         o_low_height,
    output logic [pmb_pkg::HEIGHT_W-1:0]         o_high_height,
    output logic                                 o_saturated,
    output logic                                 o_last
);

    localparam int CW = pmb_pkg::f_coord_w(TILE_SIZE);

    logic [pmb_pkg::LEVEL_W-1:0] r_level_count;
    logic                        in_take;
    logic [CW-1:0]               rs_x;
    logic [CW-1:0]               rs_y;
    pmb_pkg::t_heights           rs_h;
    logic                        e_valid;
    logic                        e_ready;
    logic [pmb_pkg::LEVEL_W-1:0] e_level;
    logic [CW-1:0]               e_x;
    logic [CW-1:0]               e_y;
    pmb_pkg::t_heights           e_h;
    logic                        e_last;

    // Take configuration transactions at any time
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_count <= pmb_pkg::LEVEL_COUNT_RST;
        end else if (i_cfg_valid) begin
            r_level_count <= i_cfg_level_count;
        end
    end

    assign in_take = i_valid && o_ready;

    pmb_raster #(
        .TILE_SIZE  (TILE_SIZE)
    ) u_raster (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (in_take),
        .i_base_min (i_base_min),
        .i_span     (i_span),
        .o_x        (rs_x),
        .o_y        (rs_y),
        .o_heights  (rs_h)
    );

    pmb_walker #(
        .TILE_SIZE  (TILE_SIZE),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_level_count (r_level_count),
        .i_in_valid    (i_valid),
        .o_in_ready    (o_ready),
        .i_in_x        (rs_x),
        .i_in_y        (rs_y),
        .i_in_heights  (rs_h),
        .i_out_ready   (e_ready),
        .o_e_valid     (e_valid),
        .o_e_level     (e_level),
        .o_e_x         (e_x),
        .o_e_y         (e_y),
        .o_e_heights   (e_h),
        .o_e_last      (e_last)
    );

    pmb_out_stage #(
        .TILE_SIZE  (TILE_SIZE)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_e_valid     (e_valid),
        .o_e_ready     (e_ready),
        .i_e_level     (e_level),
        .i_e_x         (e_x),
        .i_e_y         (e_y),
        .i_e_heights   (e_h),
        .i_e_last      (e_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_level       (o_level),
        .o_cell_x      (o_cell_x),
        .o_cell_y      (o_cell_y),
        .o_low_height  (o_low_height),
        .o_high_height (o_high_height),
        .o_saturated   (o_saturated),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire
